@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top level of the keypad code lock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KCL_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kcl assertion failed");

// Next-cycle implication, disabled while reset is high.
`define KCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kcl assertion failed");

`endif

@@ hw/rtl/kcl_pkg.sv @@
// Types, constants and register codes of the keypad code lock.
package kcl_pkg;

   localparam int MAX_CODE_KEYS_DEF = 4;
   localparam int TIMER_BITS_DEF    = 16;

   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CODE_KEYS     = 3'd0,
      CSR_CODE_LENGTH   = 3'd1,
      CSR_VERIFY_TICKS  = 3'd2,
      CSR_OPEN_TICKS    = 3'd3,
      CSR_ALERT_TICKS   = 3'd4,
      CSR_LOCKOUT_TICKS = 3'd5,
      CSR_CLEAR_TICKS   = 3'd6,
      CSR_MAX_FAILURES  = 3'd7
   } csr_index_type;

   // Item kinds and special keys
   localparam logic       REQ_KEY   = 1'b0;
   localparam logic       REQ_TICK  = 1'b1;
   localparam logic [3:0] KEY_CLEAR = 4'd14;
   localparam logic [3:0] KEY_ENTER = 4'd15;

   // Fixed beep timing, in ticks
   localparam logic [31:0] GRANT_BEEP_TICKS = 32'd150;
   localparam logic [31:0] DENY_ON_TICKS    = 32'd300;
   localparam logic [31:0] DENY_OFF_TICKS   = 32'd150;
   localparam logic [2:0]  DENY_BEEPS       = 3'd3;
   localparam logic [2:0]  FAIL_COUNT_MAX   = 3'd7;

   typedef enum logic [8:0] {
      PH_IDLE       = 9'b000000001,
      PH_CLEARED    = 9'b000000010,
      PH_VERIFY     = 9'b000000100,
      PH_GRANT_BEEP = 9'b000001000,
      PH_GRANT_OPEN = 9'b000010000,
      PH_DENY_ON    = 9'b000100000,
      PH_DENY_OFF   = 9'b001000000,
      PH_DENY_HOLD  = 9'b010000000,
      PH_LOCKOUT    = 9'b100000000
   } phase_type;

   typedef enum logic [2:0] {
      MSG_PROMPT    = 3'd0,
      MSG_VERIFYING = 3'd1,
      MSG_ACCESS_OK = 3'd2,
      MSG_WRONG     = 3'd3,
      MSG_LOCKED    = 3'd4,
      MSG_CLEARED   = 3'd5
   } msg_type;

   typedef struct packed {
      logic       req_type;
      logic [3:0] key_code;
   } req_item_type;

   typedef struct packed {
      logic       lock_open;
      logic       green_led;
      logic       red_led;
      logic       buzzer;
      logic [2:0] display_msg;
      logic [2:0] entered_count;
      logic       busy_res;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] code_keys;
      logic [2:0]  code_length;
      logic [15:0] verify_ticks;
      logic [15:0] open_ticks;
      logic [15:0] alert_ticks;
      logic [15:0] lockout_ticks;
      logic [15:0] clear_ticks;
      logic [2:0]  max_failures;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      code_keys:     16'd0,
      code_length:   3'd4,
      verify_ticks:  16'd500,
      open_ticks:    16'd4000,
      alert_ticks:   16'd1000,
      lockout_ticks: 16'd10000,
      clear_ticks:   16'd1000,
      max_failures:  3'd3
   };

endpackage

@@ hw/rtl/kcl_csr.sv @@
// Configuration register file of the keypad code lock.
module kcl_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [kcl_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [kcl_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output kcl_pkg::cfg_type                     cfg
);

   kcl_pkg::cfg_type cfg_ff;
   kcl_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (kcl_pkg::csr_index_type'(csr_index))
            kcl_pkg::CSR_CODE_KEYS:     cfg_in.code_keys     = csr_wdata;
            kcl_pkg::CSR_CODE_LENGTH:   cfg_in.code_length   = csr_wdata[2:0];
            kcl_pkg::CSR_VERIFY_TICKS:  cfg_in.verify_ticks  = csr_wdata;
            kcl_pkg::CSR_OPEN_TICKS:    cfg_in.open_ticks    = csr_wdata;
            kcl_pkg::CSR_ALERT_TICKS:   cfg_in.alert_ticks   = csr_wdata;
            kcl_pkg::CSR_LOCKOUT_TICKS: cfg_in.lockout_ticks = csr_wdata;
            kcl_pkg::CSR_CLEAR_TICKS:   cfg_in.clear_ticks   = csr_wdata;
            kcl_pkg::CSR_MAX_FAILURES:  cfg_in.max_failures  = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= kcl_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/kcl_seq.sv @@
// Phase sequencer, entry store and result decode of the keypad code lock.
module kcl_seq #(
   parameter int MAX_CODE_KEYS = kcl_pkg::MAX_CODE_KEYS_DEF,
   parameter int TIMER_BITS    = kcl_pkg::TIMER_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  kcl_pkg::req_item_type req_item,
   input  kcl_pkg::cfg_type      cfg,
   output kcl_pkg::rsp_item_type rsp_item
);

   localparam int CW         = $clog2(MAX_CODE_KEYS + 1);
   localparam int CODE_EXT_W = 4 * MAX_CODE_KEYS + 16;
   localparam logic [32:0]           TIMER_LIM = (33'd1 << TIMER_BITS) - 33'd1;
   localparam logic [TIMER_BITS-1:0] TIMER_ONE = TIMER_BITS'(1);

   // durations saturate to the timer width
   function automatic logic [TIMER_BITS-1:0] sat_ticks(input logic [31:0] ticks);
      if ({1'b0, ticks} > TIMER_LIM) begin
         return TIMER_LIM[TIMER_BITS-1:0];
      end
      return ticks[TIMER_BITS-1:0];
   endfunction

   kcl_pkg::phase_type    phase_ff, phase_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [1:0]            beep_ff, beep_in;
   logic [3:0]            keys_ff [MAX_CODE_KEYS];
   logic [3:0]            keys_in [MAX_CODE_KEYS];
   logic [CW-1:0]         count_ff, count_in;
   logic [2:0]            fail_ff, fail_in;

   logic                  match;
   logic [CODE_EXT_W-1:0] code_ext;
   logic [7:0]            count_ext;

   // length and every held key against the master code
   always_comb begin
      code_ext = CODE_EXT_W'(cfg.code_keys);
      match    = 1'b1;
      if (int'(count_ff) != int'(cfg.code_length) || cfg.code_length == 3'd0 ||
          int'(cfg.code_length) > MAX_CODE_KEYS) begin
         match = 1'b0;
      end
      for (int i = 0; i < MAX_CODE_KEYS; i++) begin
         if (i < int'(count_ff) && keys_ff[i] != code_ext[4*i +: 4]) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      beep_in  = beep_ff;
      keys_in  = keys_ff;
      count_in = count_ff;
      fail_in  = fail_ff;

      if (req_item.req_type == kcl_pkg::REQ_TICK) begin
         if (phase_ff != kcl_pkg::PH_IDLE) begin
            if (timer_ff > TIMER_ONE) begin
               timer_in = timer_ff - TIMER_ONE;
            end else begin
               unique case (phase_ff)
                  kcl_pkg::PH_VERIFY: begin
                     if (match) begin
                        fail_in  = 3'd0;
                        phase_in = kcl_pkg::PH_GRANT_BEEP;
                        timer_in = sat_ticks(kcl_pkg::GRANT_BEEP_TICKS);
                     end else begin
                        if (fail_ff < kcl_pkg::FAIL_COUNT_MAX) begin
                           fail_in = fail_ff + 3'd1;
                        end
                        beep_in  = 2'd0;
                        phase_in = kcl_pkg::PH_DENY_ON;
                        timer_in = sat_ticks(kcl_pkg::DENY_ON_TICKS);
                     end
                     for (int i = 0; i < MAX_CODE_KEYS; i++) begin
                        keys_in[i] = 4'd0;
                     end
                     count_in = '0;
                  end
                  kcl_pkg::PH_GRANT_BEEP: begin
                     phase_in = kcl_pkg::PH_GRANT_OPEN;
                     timer_in = sat_ticks(32'(cfg.open_ticks));
                  end
                  kcl_pkg::PH_DENY_ON: begin
                     phase_in = kcl_pkg::PH_DENY_OFF;
                     timer_in = sat_ticks(kcl_pkg::DENY_OFF_TICKS);
                  end
                  kcl_pkg::PH_DENY_OFF: begin
                     if ({1'b0, beep_ff} + 3'd1 < kcl_pkg::DENY_BEEPS) begin
                        beep_in  = beep_ff + 2'd1;
                        phase_in = kcl_pkg::PH_DENY_ON;
                        timer_in = sat_ticks(kcl_pkg::DENY_ON_TICKS);
                     end else begin
                        beep_in  = 2'd0;
                        phase_in = kcl_pkg::PH_DENY_HOLD;
                        timer_in = sat_ticks(32'(cfg.alert_ticks));
                     end
                  end
                  kcl_pkg::PH_DENY_HOLD: begin
                     if (fail_ff >= cfg.max_failures) begin
                        phase_in = kcl_pkg::PH_LOCKOUT;
                        timer_in = sat_ticks(32'(cfg.lockout_ticks));
                     end else begin
                        phase_in = kcl_pkg::PH_IDLE;
                        timer_in = '0;
                     end
                  end
                  kcl_pkg::PH_LOCKOUT: begin
                     fail_in  = 3'd0;
                     phase_in = kcl_pkg::PH_IDLE;
                     timer_in = '0;
                  end
                  default: begin
                     phase_in = kcl_pkg::PH_IDLE;
                     timer_in = '0;
                  end
               endcase
            end
         end
      end else if (phase_ff == kcl_pkg::PH_IDLE) begin
         priority if (req_item.key_code == kcl_pkg::KEY_ENTER) begin
            if (count_ff != '0) begin
               phase_in = kcl_pkg::PH_VERIFY;
               timer_in = sat_ticks(32'(cfg.verify_ticks));
            end
         end else if (req_item.key_code == kcl_pkg::KEY_CLEAR) begin
            for (int i = 0; i < MAX_CODE_KEYS; i++) begin
               keys_in[i] = 4'd0;
            end
            count_in = '0;
            phase_in = kcl_pkg::PH_CLEARED;
            timer_in = sat_ticks(32'(cfg.clear_ticks));
         end else begin
            // a full entry ignores further keys
            if (int'(count_ff) < MAX_CODE_KEYS) begin
               for (int i = 0; i < MAX_CODE_KEYS; i++) begin
                  if (int'(count_ff) == i) begin
                     keys_in[i] = req_item.key_code;
                  end
               end
               count_in = count_ff + CW'(1);
            end
         end
      end
   end

   // result reflects the state after the update
   always_comb begin
      count_ext              = 8'(count_in);
      rsp_item               = '0;
      rsp_item.display_msg   = kcl_pkg::MSG_PROMPT;
      rsp_item.entered_count = count_ext[2:0];
      rsp_item.busy_res      = (phase_in != kcl_pkg::PH_IDLE);
      unique case (phase_in)
         kcl_pkg::PH_CLEARED: rsp_item.display_msg = kcl_pkg::MSG_CLEARED;
         kcl_pkg::PH_VERIFY:  rsp_item.display_msg = kcl_pkg::MSG_VERIFYING;
         kcl_pkg::PH_GRANT_BEEP: begin
            rsp_item.display_msg = kcl_pkg::MSG_VERIFYING;
            rsp_item.green_led   = 1'b1;
            rsp_item.buzzer      = 1'b1;
         end
         kcl_pkg::PH_GRANT_OPEN: begin
            rsp_item.display_msg = kcl_pkg::MSG_ACCESS_OK;
            rsp_item.green_led   = 1'b1;
            rsp_item.lock_open   = 1'b1;
         end
         kcl_pkg::PH_DENY_ON: begin
            rsp_item.display_msg = kcl_pkg::MSG_VERIFYING;
            rsp_item.red_led     = 1'b1;
            rsp_item.buzzer      = 1'b1;
         end
         kcl_pkg::PH_DENY_OFF: begin
            rsp_item.display_msg = kcl_pkg::MSG_VERIFYING;
            rsp_item.red_led     = 1'b1;
         end
         kcl_pkg::PH_DENY_HOLD: begin
            rsp_item.display_msg = kcl_pkg::MSG_WRONG;
            rsp_item.red_led     = 1'b1;
         end
         kcl_pkg::PH_LOCKOUT: begin
            rsp_item.display_msg = kcl_pkg::MSG_LOCKED;
            rsp_item.red_led     = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= kcl_pkg::PH_IDLE;
         timer_ff <= '0;
         beep_ff  <= 2'd0;
         count_ff <= '0;
         fail_ff  <= 3'd0;
         for (int i = 0; i < MAX_CODE_KEYS; i++) begin
            keys_ff[i] <= 4'd0;
         end
      end else if (step) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         beep_ff  <= beep_in;
         count_ff <= count_in;
         fail_ff  <= fail_in;
         keys_ff  <= keys_in;
      end
   end

endmodule

@@ hw/rtl/keypad_code_lock_controller.sv @@
// Top level of the keypad code lock: input register, sequencer, result register.
//
//  channel | ports                          | carries
//  --------+--------------------------------+-------------------------------------
//  req     | req_valid req_ready req_data   | key event or 1 ms tick, one per item
//  rsp     | rsp_valid rsp_ready rsp_data   | LEDs, lock, buzzer, message, count
//  csr     | csr_we csr_index csr_wdata     | register write, no wait, no read-back
//
// One item per cycle sustained while the result is drained; a taken item is held in the input
// register, and its result is loaded into the result register when that item advances.
// The phase update between the input and result registers is combinational and sets that rate.
// Synchronous active-high reset empties both registers, closes the lock, clears the entry
// and failure count and loads the register defaults.
// A stalled result holds; the input register still takes one more item behind it.
`include "assert_macros.svh"

module keypad_code_lock_controller #(
   parameter int MAX_CODE_KEYS = kcl_pkg::MAX_CODE_KEYS_DEF,
   parameter int TIMER_BITS    = kcl_pkg::TIMER_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // key / tick items
   input  logic                                req_valid,
   output logic                                req_ready,
   input  kcl_pkg::req_item_type               req_data,
   // result items
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output kcl_pkg::rsp_item_type               rsp_data,
   // configuration writes
   input  logic                                csr_we,
   input  logic [kcl_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [kcl_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // input register
   logic                  in_valid_ff, in_valid_in;
   kcl_pkg::req_item_type in_item_ff, in_item_in;
   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   kcl_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   logic                  req_take;
   logic                  advance;     // held item moves into the sequencer this cycle
   kcl_pkg::cfg_type      cfg;
   kcl_pkg::rsp_item_type seq_rsp;

   // terms for the checks at the end
   logic                  stalled_full;
   logic                  open_shown;
   logic                  open_quiet;
   logic                  idle_shown;
   logic                  idle_quiet;

   kcl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kcl_seq #(
      .MAX_CODE_KEYS (MAX_CODE_KEYS),
      .TIMER_BITS    (TIMER_BITS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .req_item (in_item_ff),
      .cfg      (cfg),
      .rsp_item (seq_rsp)
   );

   // the held item advances when the result slot is empty or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign stalled_full = rsp_valid_ff && !rsp_ready && in_valid_ff;
   assign open_shown   = rsp_valid_ff && rsp_data_ff.lock_open;
   assign open_quiet   = rsp_data_ff.green_led && !rsp_data_ff.red_led && !rsp_data_ff.buzzer;
   assign idle_shown   = rsp_valid_ff && !rsp_data_ff.busy_res;
   assign idle_quiet   = rsp_data_ff.display_msg == kcl_pkg::MSG_PROMPT &&
                         !rsp_data_ff.lock_open && !rsp_data_ff.green_led &&
                         !rsp_data_ff.red_led && !rsp_data_ff.buzzer;

   // a full input register behind a stalled result must hold off the sender
   `KCL_ASSERT_IMPLIES(a_stall_blocks_input, clock, reset, stalled_full, !req_ready)
   // an item handed to the sequencer always shows up as a result next cycle
   `KCL_ASSERT_NEXT(a_advance_gives_result, clock, reset, advance, rsp_valid_ff)
   // open lock only with green, never with red or buzzer
   `KCL_ASSERT_IMPLIES(a_open_is_granted, clock, reset, open_shown, open_quiet)
   // outside a timed phase every indicator is quiet and the prompt shows
   `KCL_ASSERT_IMPLIES(a_idle_quiet, clock, reset, idle_shown, idle_quiet)

endmodule
